/* sv/ebc_pkg.sv */
package ebc_pkg;

    localparam logic [31:0] DAY_SEC  = 32'd86400;
    localparam logic [31:0] HOUR_SEC = 32'd3600;
    localparam logic [31:0] MIN_SEC  = 32'd60;
    localparam logic [31:0] WEEK_LEN = 32'd7;
    localparam logic [31:0] ZONE_SEC = 32'd3600;

    // 1970 is year offset 0, so a leap year has offset 2 mod 4
    localparam logic [1:0]  LEAP_PHASE    = 2'd2;
    localparam logic [6:0]  BASE_YEAR_OFS = 7'd30;
    localparam logic [6:0]  FALLBACK_YEAR = 7'd26;
    localparam logic [2:0]  WDAY_EPOCH    = 3'd4;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [2:0] wday;
        logic [4:0] mday;
        logic [3:0] mon;
        logic [6:0] year_ofs;
    } t_fields;

    typedef struct packed {
        logic [6:0] seconds;
        logic [6:0] minutes;
        logic [5:0] hours;
        logic [2:0] weekday;
        logic [5:0] day;
        logic [4:0] month;
        logic [7:0] year;
    } t_bcd;

    function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
        logic [4:0] md;
        case (mo)
            4'd0:    md = 5'd31;
            4'd1:    md = leap ? 5'd29 : 5'd28;
            4'd2:    md = 5'd31;
            4'd3:    md = 5'd30;
            4'd4:    md = 5'd31;
            4'd5:    md = 5'd30;
            4'd6:    md = 5'd31;
            4'd7:    md = 5'd31;
            4'd8:    md = 5'd30;
            4'd9:    md = 5'd31;
            4'd10:   md = 5'd30;
            4'd11:   md = 5'd31;
            default: md = 5'd31;
        endcase
        return md;
    endfunction

    // tens by reciprocal multiply, exact for values below 100
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - 7'(7'(tens) * 7'd10);
        return {tens, units[3:0]};
    endfunction

endpackage

/* sv/ebc_cmpsub.sv */
module ebc_cmpsub (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_diff,
    output logic        o_ge
);
    logic [32:0] w_sub;

    // a - b with borrow, ge when no borrow
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_sub[31:0];
    assign o_ge   = ~w_sub[32];

endmodule

/* sv/ebc_fmt.sv */
module ebc_fmt (
    input  ebc_pkg::t_fields i_fields,
    output ebc_pkg::t_bcd    o_bcd
);
    import ebc_pkg::*;

    logic [6:0] w_year2;
    logic [7:0] w_sec;
    logic [7:0] w_min;
    logic [7:0] w_hour;
    logic [7:0] w_day;
    logic [7:0] w_mon;
    logic [7:0] w_year;

    // years before 2000 fall back; the range never reaches 2100
    assign w_year2 = (i_fields.year_ofs >= BASE_YEAR_OFS) ?
                     7'(i_fields.year_ofs - BASE_YEAR_OFS) : FALLBACK_YEAR;

    assign w_sec  = to_bcd({1'b0, i_fields.sec});
    assign w_min  = to_bcd({1'b0, i_fields.min});
    assign w_hour = to_bcd({2'b0, i_fields.hour});
    assign w_day  = to_bcd({2'b0, i_fields.mday});
    assign w_mon  = to_bcd({3'b0, i_fields.mon});
    assign w_year = to_bcd(w_year2);

    assign o_bcd.seconds = w_sec[6:0];
    assign o_bcd.minutes = w_min[6:0];
    assign o_bcd.hours   = w_hour[5:0];
    assign o_bcd.weekday = i_fields.wday;
    assign o_bcd.day     = w_day[5:0];
    assign o_bcd.month   = w_mon[4:0];
    assign o_bcd.year    = w_year;

endmodule

/* sv/epoch_to_bcd_calendar.sv */
// channel   | direction | beat marked by               | payload
// ----------+-----------+------------------------------+------------------------------
// command   | in        | start high while busy low    | i_utc_seconds
// result    | out       | o_done, one cycle            | o_seconds_bcd .. o_year_bcd
// config    | in        | i_cfg_valid and o_cfg_ready  | i_zone_offset_hours
//
// one conversion runs on a shared 32-bit compare-subtract unit: 15 day-division steps,
// 5 hour, 6 minute and 12 weekday steps, then one step per year and per month
// o_done pulses for one cycle with the result on the ports; results hold until the next one
// busy drops in the cycle o_done rises, so a new command may be taken alongside it
// the receiver cannot stall; reset clears the sequencer and sets the zone offset to zero
module epoch_to_bcd_calendar (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_utc_seconds,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [4:0]  i_zone_offset_hours,
    output logic               o_done,
    output logic [6:0]         o_seconds_bcd,
    output logic [6:0]         o_minutes_bcd,
    output logic [5:0]         o_hours_bcd,
    output logic [2:0]         o_weekday_bcd,
    output logic [5:0]         o_day_bcd,
    output logic [4:0]         o_month_bcd,
    output logic [7:0]         o_year_bcd
);
    import ebc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DAY, S_HOUR, S_MIN, S_WDAY, S_YEAR, S_MONTH, S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic        r_done;
    logic [31:0] r_off_sec;        // zone offset in seconds, two's complement
    logic [31:0] r_rem,  n_rem;    // running remainder of the current division
    logic [14:0] r_days, n_days;   // days since epoch, later day within month
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min,  n_min;
    logic [5:0]  r_sec,  n_sec;
    logic [2:0]  r_wd,   n_wd;
    logic [6:0]  r_yo,   n_yo;     // years since 1970
    logic [3:0]  r_mo,   n_mo;     // month index from 0
    logic [3:0]  r_step, n_step;   // bit position of the shifted divisor
    t_bcd        r_bcd;

    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_diff;
    logic        w_ge;
    logic        w_leap;
    logic [31:0] w_sum;
    logic [31:0] w_local;
    logic [31:0] w_off_ext;
    t_fields     w_fields;
    t_bcd        w_bcd;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);

    // local time, negative sums clamp to the epoch
    assign w_sum   = i_utc_seconds + r_off_sec;
    assign w_local = w_sum[31] ? 32'd0 : w_sum;

    assign w_off_ext = 32'(i_zone_offset_hours);

    // within 1970..2038 the only century year is 2000, a leap year
    assign w_leap = (r_yo[1:0] == LEAP_PHASE);

    // operand selection for the shared unit
    always_comb begin
        w_a = r_rem;
        w_b = 32'd0;
        case (r_state)
            S_DAY:   w_b = DAY_SEC << r_step;
            S_HOUR:  w_b = HOUR_SEC << r_step;
            S_MIN:   w_b = MIN_SEC << r_step;
            S_WDAY:  w_b = WEEK_LEN << r_step;
            S_YEAR: begin
                w_a = {17'd0, r_days};
                w_b = w_leap ? 32'd366 : 32'd365;
            end
            S_MONTH: begin
                w_a = {17'd0, r_days};
                w_b = {27'd0, month_days(r_mo, w_leap)};
            end
            default: w_b = 32'd0;
        endcase
    end

    ebc_cmpsub u_cmpsub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_days  = r_days;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_wd    = r_wd;
        n_yo    = r_yo;
        n_mo    = r_mo;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rem   = w_local;
                    n_days  = 15'd0;
                    n_step  = 4'd14;
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                if (w_ge) begin
                    n_rem          = w_diff;
                    n_days[r_step] = 1'b1;
                end
                if (r_step == 4'd0) begin
                    n_hour  = 5'd0;
                    n_step  = 4'd4;
                    n_state = S_HOUR;
                end else begin
                    n_step = r_step - 4'd1;
                end
            end
            S_HOUR: begin
                if (w_ge) begin
                    n_rem               = w_diff;
                    n_hour[r_step[2:0]] = 1'b1;
                end
                if (r_step == 4'd0) begin
                    n_min   = 6'd0;
                    n_step  = 4'd5;
                    n_state = S_MIN;
                end else begin
                    n_step = r_step - 4'd1;
                end
            end
            S_MIN: begin
                if (w_ge) begin
                    n_rem              = w_diff;
                    n_min[r_step[2:0]] = 1'b1;
                end
                if (r_step == 4'd0) begin
                    // seconds are what is left; reuse the remainder for the weekday
                    n_sec   = n_rem[5:0];
                    n_rem   = 32'(r_days) + 32'(WDAY_EPOCH);
                    n_step  = 4'd11;
                    n_state = S_WDAY;
                end else begin
                    n_step = r_step - 4'd1;
                end
            end
            S_WDAY: begin
                if (w_ge) begin
                    n_rem = w_diff;
                end
                if (r_step == 4'd0) begin
                    n_wd    = n_rem[2:0] + 3'd1;
                    n_yo    = 7'd0;
                    n_state = S_YEAR;
                end else begin
                    n_step = r_step - 4'd1;
                end
            end
            S_YEAR: begin
                if (w_ge) begin
                    n_days = w_diff[14:0];
                    n_yo   = r_yo + 7'd1;
                end else begin
                    n_mo    = 4'd0;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (w_ge && (r_mo != LAST_MONTH)) begin
                    n_days = w_diff[14:0];
                    n_mo   = r_mo + 4'd1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_fields.sec      = r_sec;
    assign w_fields.min      = r_min;
    assign w_fields.hour     = r_hour;
    assign w_fields.wday     = r_wd;
    assign w_fields.mday     = r_days[4:0] + 5'd1;
    assign w_fields.mon      = r_mo + 4'd1;
    assign w_fields.year_ofs = r_yo;

    ebc_fmt u_fmt (
        .i_fields (w_fields),
        .o_bcd    (w_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_off_sec <= 32'd0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_OUT);
            if (i_cfg_valid && o_cfg_ready) begin
                r_off_sec <= 32'(w_off_ext * ZONE_SEC);
            end
        end
        r_rem  <= n_rem;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_wd   <= n_wd;
        r_yo   <= n_yo;
        r_mo   <= n_mo;
        r_step <= n_step;
        if (r_state == S_OUT) begin
            r_bcd <= w_bcd;
        end
    end

    assign o_done        = r_done;
    assign o_seconds_bcd = r_bcd.seconds;
    assign o_minutes_bcd = r_bcd.minutes;
    assign o_hours_bcd   = r_bcd.hours;
    assign o_weekday_bcd = r_bcd.weekday;
    assign o_day_bcd     = r_bcd.day;
    assign o_month_bcd   = r_bcd.month;
    assign o_year_bcd    = r_bcd.year;

    // a taken command keeps the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command");

    // each result is a single pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // the month walk never passes december
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH) |-> (r_mo <= LAST_MONTH))
        else $error("month index out of range");

    // 31-bit local time cannot pass 2038
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR) |-> (r_yo <= 7'd68))
        else $error("year count out of range");

    a_weekday_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_weekday_bcd != 3'd0))
        else $error("weekday zero on result");

endmodule

/* test/tb_epoch_to_bcd_calendar.sv */
module tb_epoch_to_bcd_calendar;

    timeunit 1ns;
    timeprecision 1ps;

    import ebc_pkg::*;

    // cycles with no accepted beat on any channel before the run is abandoned;
    // covers the longest sender gap plus a full conversion with wide margin
    localparam int STALL_LIMIT  = 2000;
    // settle time after the last result, a little above the worst conversion
    localparam int TAIL_CYCLES  = 130;
    localparam int BATCH_ITEMS  = 20;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [31:0]        i_utc_seconds = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic signed [4:0]  i_zone_offset_hours = '0;
    logic               o_done;
    logic [6:0]         o_seconds_bcd;
    logic [6:0]         o_minutes_bcd;
    logic [5:0]         o_hours_bcd;
    logic [2:0]         o_weekday_bcd;
    logic [5:0]         o_day_bcd;
    logic [4:0]         o_month_bcd;
    logic [7:0]         o_year_bcd;

    // expected calendar results, oldest first
    t_bcd               expected_dates[$];
    // the zone offset the block holds, as last written
    logic signed [4:0]  zone_now = '0;
    logic [31:0]        zones_written = '0;
    int                 fail_count = 0;
    int                 items_sent = 0;
    int                 dates_seen = 0;
    int                 batch_count = 0;

    epoch_to_bcd_calendar DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_utc_seconds       (i_utc_seconds),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_zone_offset_hours (i_zone_offset_hours),
        .o_done              (o_done),
        .o_seconds_bcd       (o_seconds_bcd),
        .o_minutes_bcd       (o_minutes_bcd),
        .o_hours_bcd         (o_hours_bcd),
        .o_weekday_bcd       (o_weekday_bcd),
        .o_day_bcd           (o_day_bcd),
        .o_month_bcd         (o_month_bcd),
        .o_year_bcd          (o_year_bcd)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------

    // gregorian rule: every fourth year, but not centuries unless divisible by 400
    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned mo, input bit leap);
        case (mo)
            1:       return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default: return 31;
        endcase
    endfunction

    // tens in the high nibble, units in the low one
    function automatic logic [7:0] packed_bcd(input int unsigned v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic t_bcd calendar_of(input logic [31:0] utc, input logic signed [4:0] zone);
        logic [31:0]  loc_secs;
        int unsigned  days;
        int unsigned  rem;
        int unsigned  yr;
        int unsigned  mo;
        int unsigned  yy;
        int unsigned  ylen;
        bit           found;
        t_bcd         r;
        // offset is sign-extended, scaled and added with 32-bit wrap
        loc_secs = utc + 32'(int'(zone) * 3600);
        // anything that reads as negative collapses to the epoch
        if (loc_secs[31]) begin
            loc_secs = '0;
        end
        days = loc_secs / 32'd86400;
        rem  = loc_secs % 32'd86400;
        r.hours   = 6'(packed_bcd(rem / 3600));
        rem       = rem % 3600;
        r.minutes = 7'(packed_bcd(rem / 60));
        r.seconds = 7'(packed_bcd(rem % 60));
        // day zero was a thursday; sunday is 1
        r.weekday = 3'(packed_bcd((days + 4) % 7 + 1));
        yr = 1970;
        ylen = leap_year(yr) ? 366 : 365;
        while (days >= ylen) begin
            days -= ylen;
            yr++;
            ylen = leap_year(yr) ? 366 : 365;
        end
        mo = 0;
        found = 1'b0;
        while (!found && mo < 12) begin
            if (days < month_length(mo, leap_year(yr))) begin
                found = 1'b1;
            end else begin
                days -= month_length(mo, leap_year(yr));
                mo++;
            end
        end
        if (mo > 11) begin
            mo = 11;
        end
        // two-digit year only inside 2000..2099
        yy = (yr >= 2000 && yr - 2000 <= 99) ? yr - 2000 : 26;
        r.day   = 6'(packed_bcd(days + 1));
        r.month = 5'(packed_bcd(mo + 1));
        r.year  = packed_bcd(yy);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker: one beat per o_done cycle, receiver never stalls
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bcd want;
        if (i_rst_n && o_done) begin
            dates_seen++;
            if (expected_dates.size() == 0) begin
                $error("result beat with no command outstanding");
                fail_count++;
            end else begin
                want = expected_dates.pop_front();
                check_field("seconds_bcd", 8'(want.seconds), 8'(o_seconds_bcd));
                check_field("minutes_bcd", 8'(want.minutes), 8'(o_minutes_bcd));
                check_field("hours_bcd",   8'(want.hours),   8'(o_hours_bcd));
                check_field("weekday_bcd", 8'(want.weekday), 8'(o_weekday_bcd));
                check_field("day_bcd",     8'(want.day),     8'(o_day_bcd));
                check_field("month_bcd",   8'(want.month),   8'(o_month_bcd));
                check_field("year_bcd",    want.year,        o_year_bcd);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: counts cycles in which no beat moves on any channel
    // ------------------------------------------------------------------

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------

    // one command beat; gap is the number of idle cycles before it. start is only
    // touched at falling edges and never twice in one, so back-to-back beats keep it high
    task automatic send_epoch(input logic [31:0] utc, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_utc_seconds <= utc;
        do @(posedge i_clk); while (busy);
        expected_dates.push_back(calendar_of(utc, zone_now));
        items_sent++;
    endtask

    // drop start and wait until every expected result is in and the block is free
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic zone_write(input logic signed [4:0] zone);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_zone_offset_hours <= zone;
        do @(posedge i_clk); while (!o_cfg_ready);
        zone_now = zone;
        zones_written[$unsigned(zone)] = 1'b1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // idle cycles before the next beat: mostly short, now and then longer
    // than a whole conversion so gaps land on every stage of the sequencer
    function automatic int pick_gap(input int idle_pct);
        if ($urandom_range(99) >= idle_pct) begin
            return 0;
        end
        return ($urandom_range(7) == 0) ? $urandom_range(140, 7) : $urandom_range(6, 1);
    endfunction

    // times biased towards the edges that matter: the epoch, the sign bit,
    // the top of the 32-bit range, midnight and the turn of 2000
    function automatic logic [31:0] pick_epoch();
        case ($urandom_range(6))
            0:       return $urandom;
            1:       return $urandom & 32'h7FFF_FFFF;
            2:       return $urandom_range(200000);
            3:       return 32'h8000_0000 + $urandom_range(120000) - 32'd60000;
            4:       return 32'hFFFF_FFFF - $urandom_range(100000);
            5:       return 32'($urandom_range(24855)) * 32'd86400 + $urandom_range(3) - 32'd2;
            default: return 32'd946684800 + $urandom_range(200000) - 32'd100000;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_reset_and_edges();
        // offset straight out of reset is zero, no write yet
        send_epoch(32'd0, 0);               // epoch itself, a thursday, year out of window
        send_epoch(32'hFFFF_FFFF, 0);       // negative local time, clamps to epoch
        send_epoch(32'h7FFF_FFFF, 0);       // last positive second, 2038
        send_epoch(32'h8000_0000, 0);       // first negative value
        send_epoch(32'd946684799, 0);       // last second of 1999
        send_epoch(32'd946684800, 0);       // first second of 2000
        send_epoch(32'd951782400, 0);       // 29 feb 2000, century leap year
        send_epoch(32'd951868800, 0);       // 1 mar 2000
        send_epoch(32'd68169600, 0);        // 29 feb 1972
        send_epoch(32'd1078012800, 0);      // 29 feb 2004
        send_epoch(32'd2145916799, 0);      // new year's eve 2037, 23:59:59
        send_epoch(32'd86399, 0);           // end of the first day
        send_epoch(32'd1234567890, 0);
    endtask

    task automatic test_offset_wrap();
        // negative offset pulls a negative sum back into range, or pushes zero below it
        zone_write(-5'sd1);
        send_epoch(32'h8000_0000, 0);
        send_epoch(32'd0, 0);
        // beyond the nominal range: +15 wraps the top of the range round to small times
        zone_write(5'sd15);
        send_epoch(32'hFFFF_FFFF, 0);
        send_epoch(32'h7FFF_FFFF, 0);
        send_epoch(32'h7FFF_0000, 0);
        // most negative register value, -16 hours
        zone_write(-5'sd16);
        send_epoch(32'h8000_0064, 0);
        send_epoch(32'd57599, 0);
        send_epoch(32'd57600, 0);
    endtask

    // batches of random times; the first 32 batches of the run step through every
    // register value, later ones pick one at random
    task automatic test_random_phase(input int batches, input int idle_pct);
        repeat (batches) begin
            zone_write((batch_count < 32) ? 5'(batch_count) : 5'($urandom_range(31)));
            batch_count++;
            repeat (BATCH_ITEMS) begin
                send_epoch(pick_epoch(), pick_gap(idle_pct));
            end
        end
    endtask

    // sender holds back until every expected result has arrived
    task automatic test_sender_waits();
        zone_write(5'sd14);
        repeat (6) begin
            send_epoch(pick_epoch(), 0);
            wait_idle();
        end
        zone_write(-5'sd12);
        repeat (6) begin
            send_epoch(pick_epoch(), 0);
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_and_edges();
        test_offset_wrap();
        test_random_phase(13, 0);
        test_random_phase(12, 79);
        test_sender_waits();
        test_random_phase(13, 26);
        test_random_phase(12, 0);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d conversions, %0d results checked", items_sent, dates_seen);
        $display("zone offsets written: %0d of 32, sender gaps at 0, 26 and 79 percent",
                 $countones(zones_written));
        if (fail_count == 0 && expected_dates.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, expected_dates.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/ebc_pkg.sv
sv/ebc_cmpsub.sv
sv/ebc_fmt.sv
sv/epoch_to_bcd_calendar.sv
test/tb_epoch_to_bcd_calendar.sv
